/* design/dps_pkg.sv */
// Shared types and constants for the dynamic priority scheduler.
// No dependencies; used by dps_engine and dynamic_priority_scheduler_top.
package dps_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int PID_W     = 4;
	localparam int PRIO_W    = 8;
	localparam int TIME_W    = 16;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [2:0] {
		STAT_LOADED   = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_REJECTED = 3'd2,
		STAT_RAN      = 3'd3,
		STAT_FINISHED = 3'd4,
		STAT_IDLE     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_SCAN,
		S_UPD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              op;
		logic [PRIO_W-1:0] priority_req;
		logic [TIME_W-1:0] run_time;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic [PID_W-1:0]  process_id;
		logic [PRIO_W-1:0] new_priority;
		logic [TIME_W-1:0] work_done;
	} rsp_t;

	// one process table row
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] run_time;
		logic [TIME_W-1:0] work_done;
	} entry_t;

endpackage

/* design/dps_engine.sv */
// Scheduler engine: process table memory, valid bits, scan sequencer and
// the single priority comparator. Depends on dps_pkg.
module dps_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  dps_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_take,
	output dps_pkg::rsp_t res
);

	dps_pkg::state_t state_q, state_d;

	dps_pkg::cmd_t                    cmd_q;
	logic [dps_pkg::MAX_PROCS-1:0]    valid_q;
	logic [dps_pkg::CNT_W-1:0]        next_q;
	logic [dps_pkg::CNT_W-1:0]        scan_q;
	dps_pkg::entry_t                  table_q [dps_pkg::MAX_PROCS];

	dps_pkg::entry_t                  rd_s1;
	logic [dps_pkg::IDX_W-1:0]        cmp_idx_s1;
	logic                             cmp_vld_s1;

	logic                             found_q;
	logic [dps_pkg::IDX_W-1:0]        best_idx_q;
	dps_pkg::entry_t                  best_q;
	dps_pkg::rsp_t                    res_q;

	logic                             accept;
	logic                             scan_end;
	logic [dps_pkg::IDX_W-1:0]        scan_idx;
	logic [dps_pkg::IDX_W-1:0]        next_idx;
	logic                             load_full;
	logic                             load_ok;
	logic                             take_best;
	logic [dps_pkg::TIME_W-1:0]       work_nx;
	logic                             fin;
	logic [dps_pkg::PRIO_W-1:0]       new_prio;
	logic                             wr_en;
	logic [dps_pkg::IDX_W-1:0]        wr_addr;
	dps_pkg::entry_t                  wr_data;

	assign accept    = cmd_valid && !cmd_stall;
	assign scan_end  = (scan_q == dps_pkg::CNT_W'(dps_pkg::MAX_PROCS));
	assign scan_idx  = scan_q[dps_pkg::IDX_W-1:0];
	assign next_idx  = next_q[dps_pkg::IDX_W-1:0];
	assign load_full = (next_q >= dps_pkg::CNT_W'(dps_pkg::MAX_PROCS));
	assign load_ok   = (cmd_q.run_time != '0) && !load_full;

	// shared comparator: strict greater keeps the lowest number on a tie
	assign take_best = (state_q == dps_pkg::S_SCAN) && cmp_vld_s1 &&
		(!found_q || (rd_s1.prio > best_q.prio));

	assign work_nx  = best_q.work_done + dps_pkg::TIME_W'(1);
	assign fin      = (work_nx == best_q.run_time);
	assign new_prio = fin ? best_q.prio :
		((best_q.prio != '0) ? best_q.prio - dps_pkg::PRIO_W'(1) : best_q.prio);

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dps_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_stall = 1'b1;
		res_valid = 1'b0;
		unique case (state_q)
			dps_pkg::S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					state_d = (cmd.op == dps_pkg::OP_TICK) ? dps_pkg::S_SCAN : dps_pkg::S_LOAD;
				end
			end
			dps_pkg::S_LOAD: begin
				state_d = dps_pkg::S_DONE;
			end
			dps_pkg::S_SCAN: begin
				if (scan_end) begin
					state_d = dps_pkg::S_UPD;
				end
			end
			dps_pkg::S_UPD: begin
				state_d = dps_pkg::S_DONE;
			end
			dps_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = dps_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dps_pkg::S_IDLE;
			end
		endcase
	end

	// single write port: a load fills a new row, a tick rewrites the chosen row
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = best_idx_q;
		wr_data = '{prio: new_prio, run_time: best_q.run_time, work_done: work_nx};
		if (state_q == dps_pkg::S_LOAD) begin
			wr_en   = load_ok;
			wr_addr = next_idx;
			wr_data = '{prio: cmd_q.priority_req, run_time: cmd_q.run_time,
				work_done: '0};
		end else if (state_q == dps_pkg::S_UPD) begin
			wr_en = found_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_addr] <= wr_data;
		end
		if (state_q == dps_pkg::S_SCAN) begin
			rd_s1      <= table_q[scan_idx];
			cmp_idx_s1 <= scan_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			next_q     <= '0;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			if (accept) begin
				scan_q     <= '0;
				cmp_vld_s1 <= 1'b0;
				found_q    <= 1'b0;
			end
			if (state_q == dps_pkg::S_SCAN) begin
				if (scan_end) begin
					cmp_vld_s1 <= 1'b0;
				end else begin
					cmp_vld_s1 <= valid_q[scan_idx];
					scan_q     <= scan_q + dps_pkg::CNT_W'(1);
				end
			end
			if (take_best) begin
				found_q <= 1'b1;
			end
			if ((state_q == dps_pkg::S_LOAD) && load_ok) begin
				valid_q[next_idx] <= 1'b1;
				next_q            <= next_q + dps_pkg::CNT_W'(1);
			end
			if ((state_q == dps_pkg::S_UPD) && found_q && fin) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (take_best) begin
			best_idx_q <= cmp_idx_s1;
			best_q     <= rd_s1;
		end
		if (state_q == dps_pkg::S_LOAD) begin
			priority if (cmd_q.run_time == '0) begin
				res_q <= '{status: dps_pkg::STAT_REJECTED, process_id: '0,
					new_priority: '0, work_done: '0};
			end else if (load_full) begin
				res_q <= '{status: dps_pkg::STAT_FULL, process_id: '0,
					new_priority: '0, work_done: '0};
			end else begin
				res_q <= '{status: dps_pkg::STAT_LOADED,
					process_id: dps_pkg::PID_W'(next_q),
					new_priority: cmd_q.priority_req, work_done: '0};
			end
		end
		if (state_q == dps_pkg::S_UPD) begin
			if (!found_q) begin
				res_q <= '{status: dps_pkg::STAT_IDLE, process_id: '0,
					new_priority: '0, work_done: '0};
			end else begin
				res_q <= '{status: fin ? dps_pkg::STAT_FINISHED : dps_pkg::STAT_RAN,
					process_id: dps_pkg::PID_W'(best_idx_q),
					new_priority: new_prio, work_done: work_nx};
			end
		end
	end

	// the entry picked by the scan must still be live when it is updated
	a_best_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dps_pkg::S_UPD && found_q) |-> valid_q[best_idx_q])
		else $error("scheduled entry not valid at update");

	// a finished process has left the table by the time its result is offered
	a_fin_retired: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dps_pkg::S_DONE && res_q.status == dps_pkg::STAT_FINISHED)
		|-> !valid_q[best_idx_q])
		else $error("finished process still valid");

	// numbers are handed out once and stop at the table size
	a_next_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(next_q <= dps_pkg::CNT_W'(dps_pkg::MAX_PROCS)) &&
		((next_q == $past(next_q)) || (next_q == $past(next_q) + dps_pkg::CNT_W'(1))))
		else $error("process number counter out of step");

	// a scan always runs its full length before the update
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dps_pkg::S_UPD) |-> $past(state_q == dps_pkg::S_SCAN && scan_end))
		else $error("update entered without a complete scan");

endmodule

/* design/dynamic_priority_scheduler_top.sv */
// A load passes through the LOAD and DONE states, a tick through SCAN, UPD and DONE; the
// result then moves to the output register. A new transaction is taken only when idle. A
// tick scans all MAX_PROCS rows via the single registered read port and one comparator.
// Reset (arst_n, asynchronous, active low) empties the table and restarts numbering
// at zero; the block is idle after reset and ready to take a transaction.
// Depends on dps_pkg and dps_engine.
module dynamic_priority_scheduler_top (
	input  logic          clk,
	input  logic          arst_n,
	// command channel
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  dps_pkg::cmd_t cmd,
	// response channel
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dps_pkg::rsp_t rsp
);

	logic          res_valid;
	logic          res_take;
	dps_pkg::rsp_t res;

	logic          rsp_valid_q;
	dps_pkg::rsp_t rsp_q;

	// Engine: takes one command at a time, walks the table for a tick and
	// holds its result until the output register has room.
	dps_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// Output register: frees the engine as soon as a result is parked here,
	// so the next command can start while the consumer still stalls.
	assign res_take = res_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload only moves when a new result is loaded, so a stalled one holds
	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
